FILE: design/seat_zone_classifier_vote_filter_defines.svh
// ----------------------------------------------------------------------------
// Seat zone classifier vote filter: assertion macros
// Check macros used by the block's top-level RTL file, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef SEAT_ZONE_CLASSIFIER_VOTE_FILTER_DEFINES_SVH
`define SEAT_ZONE_CLASSIFIER_VOTE_FILTER_DEFINES_SVH

// Check that holds outside reset.
`define SZCVF_CHECK(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("szcvf check failed");

// Check that also covers the reset cycles.
`define SZCVF_CHECK_RST(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("szcvf reset check failed");

`endif

FILE: design/szcvf_pkg.sv
// ----------------------------------------------------------------------------
// szcvf_pkg
// Types, zone codes and the rectangle table of the seat zone classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package szcvf_pkg;

    localparam int ZONE_W     = 4;
    localparam int ZONE_COUNT = 16;
    localparam int TALLY_W    = 7;
    localparam int RECT_COUNT = 13;
    localparam int POS_W      = 16;

    localparam logic [ZONE_W-1:0]  ZONE_FINDING = 4'd2;
    localparam logic [ZONE_W-1:0]  ZONE_FIRST   = 4'd3;
    localparam logic [TALLY_W-1:0] VOTE_MIN     = 7'd2;

    // user_mode codes
    localparam logic [1:0] MODE_IN_CAR  = 2'd0;
    localparam logic [1:0] MODE_OUT_CAR = 2'd1;

    // strongest_node codes that force an in-car zone
    localparam logic [2:0] NODE_DRIVER    = 3'd1;
    localparam logic [2:0] NODE_PASSENGER = 3'd2;
    localparam logic [2:0] NODE_BACK_L    = 3'd3;
    localparam logic [2:0] NODE_BACK_R    = 3'd4;

    localparam logic [ZONE_W-1:0] ZONE_DRIVER    = 4'd3;
    localparam logic [ZONE_W-1:0] ZONE_PASSENGER = 4'd4;
    localparam logic [ZONE_W-1:0] ZONE_BACK_L    = 4'd5;
    localparam logic [ZONE_W-1:0] ZONE_BACK_R    = 4'd7;

    // First and last table entries of each mode's range
    localparam int IN_CAR_FIRST  = 0;
    localparam int IN_CAR_LAST   = 4;
    localparam int OUT_CAR_FIRST = 5;
    localparam int OUT_CAR_LAST  = 12;

    // Q8.8 thresholds
    localparam logic signed [POS_W-1:0] Q_M20   = -16'sd5120;
    localparam logic signed [POS_W-1:0] Q_P20   = 16'sd5120;
    localparam logic signed [POS_W-1:0] Q_P0_4  = 16'sd102;
    localparam logic signed [POS_W-1:0] Q_P0_7  = 16'sd179;
    localparam logic signed [POS_W-1:0] Q_M1_0  = -16'sd256;
    localparam logic signed [POS_W-1:0] Q_P3_0  = 16'sd768;
    localparam logic signed [POS_W-1:0] Q_M0_5  = -16'sd128;
    localparam logic signed [POS_W-1:0] Q_P2_0  = 16'sd512;

    typedef struct packed {
        logic signed [POS_W-1:0] xlo;
        logic signed [POS_W-1:0] xhi;
        logic signed [POS_W-1:0] ylo;
        logic signed [POS_W-1:0] yhi;
    } rect_t;

    // Half-open rectangles, entry i is zone i + 3
    localparam rect_t RECT_TAB [RECT_COUNT] = '{
        '{Q_M20,  Q_P0_4, Q_M20,  Q_P0_7},
        '{Q_M20,  Q_P0_4, Q_P0_7, Q_P20 },
        '{Q_P0_4, Q_P20,  Q_M20,  Q_P0_4},
        '{Q_P0_4, Q_P20,  Q_P0_4, Q_P0_7},
        '{Q_P0_4, Q_P20,  Q_P0_7, Q_P20 },
        '{Q_M1_0, Q_P3_0, Q_M20,  Q_P0_7},
        '{Q_M1_0, Q_P3_0, Q_P0_7, Q_P20 },
        '{Q_M20,  Q_P0_7, Q_M0_5, Q_P2_0},
        '{Q_P0_7, Q_P20,  Q_M0_5, Q_P2_0},
        '{Q_M20,  Q_M1_0, Q_M20,  Q_M0_5},
        '{Q_P3_0, Q_P20,  Q_M20,  Q_M0_5},
        '{Q_M20,  Q_M1_0, Q_P2_0, Q_P20 },
        '{Q_P3_0, Q_P20,  Q_P2_0, Q_P20 }
    };

    // Tally update request from the window stage
    typedef struct packed {
        logic              valid;
        logic [ZONE_W-1:0] zone;
        logic              evict;
        logic [ZONE_W-1:0] old_zone;
    } tally_upd_t;

endpackage

`default_nettype wire

FILE: design/szcvf_classify.sv
// ----------------------------------------------------------------------------
// szcvf_classify
// Maps one position estimate to its zone by first-match rectangle lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module szcvf_classify (
    input  wire logic signed [szcvf_pkg::POS_W-1:0]  x_pos,
    input  wire logic signed [szcvf_pkg::POS_W-1:0]  y_pos,
    input  wire logic        [1:0]                   user_mode,
    input  wire logic        [2:0]                   strongest_node,
    output logic             [szcvf_pkg::ZONE_W-1:0] zone
);

    logic [szcvf_pkg::RECT_COUNT-1:0] hit;
    logic [szcvf_pkg::ZONE_W-1:0]     zone_in;
    logic [szcvf_pkg::ZONE_W-1:0]     zone_out;

    always_comb begin
        for (int i = 0; i < szcvf_pkg::RECT_COUNT; i++) begin
            hit[i] = (x_pos >= szcvf_pkg::RECT_TAB[i].xlo) &&
                     (x_pos <  szcvf_pkg::RECT_TAB[i].xhi) &&
                     (y_pos >= szcvf_pkg::RECT_TAB[i].ylo) &&
                     (y_pos <  szcvf_pkg::RECT_TAB[i].yhi);
        end
    end

    // Scan from the back so the lowest matching entry wins
    always_comb begin
        zone_in = szcvf_pkg::ZONE_FINDING;
        for (int i = szcvf_pkg::IN_CAR_LAST; i >= szcvf_pkg::IN_CAR_FIRST; i--) begin
            if (hit[i]) begin
                zone_in = szcvf_pkg::ZONE_FIRST + 4'(i);
            end
        end
        unique case (strongest_node)
            szcvf_pkg::NODE_DRIVER:    zone_in = szcvf_pkg::ZONE_DRIVER;
            szcvf_pkg::NODE_PASSENGER: zone_in = szcvf_pkg::ZONE_PASSENGER;
            szcvf_pkg::NODE_BACK_L:    zone_in = szcvf_pkg::ZONE_BACK_L;
            szcvf_pkg::NODE_BACK_R:    zone_in = szcvf_pkg::ZONE_BACK_R;
            default: ;
        endcase
    end

    always_comb begin
        zone_out = szcvf_pkg::ZONE_FINDING;
        for (int i = szcvf_pkg::OUT_CAR_LAST; i >= szcvf_pkg::OUT_CAR_FIRST; i--) begin
            if (hit[i]) begin
                zone_out = szcvf_pkg::ZONE_FIRST + 4'(i);
            end
        end
    end

    always_comb begin
        zone = szcvf_pkg::ZONE_FINDING;
        if (x_pos != '0 || y_pos != '0) begin
            unique case (user_mode)
                szcvf_pkg::MODE_IN_CAR:  zone = zone_in;
                szcvf_pkg::MODE_OUT_CAR: zone = zone_out;
                default:                 zone = szcvf_pkg::ZONE_FINDING;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/szcvf_tally.sv
// ----------------------------------------------------------------------------
// szcvf_tally
// Per-zone vote counters with an incremental update and an argmax tree.
// ----------------------------------------------------------------------------
`default_nettype none

module szcvf_tally (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire szcvf_pkg::tally_upd_t               upd,
    output logic [szcvf_pkg::ZONE_W-1:0]             best_zone,
    output logic [szcvf_pkg::TALLY_W-1:0]            best_votes
);

    localparam int TW = szcvf_pkg::TALLY_W;
    localparam int ZW = szcvf_pkg::ZONE_W;
    localparam int ZN = szcvf_pkg::ZONE_COUNT;

    logic [TW-1:0] tally_reg  [ZN];
    logic [TW-1:0] tally_next [ZN];

    logic [TW-1:0] v1 [8];
    logic [ZW-1:0] z1 [8];
    logic [TW-1:0] v2 [4];
    logic [ZW-1:0] z2 [4];
    logic [TW-1:0] v3 [2];
    logic [ZW-1:0] z3 [2];

    always_comb begin
        for (int i = 0; i < ZN; i++) begin
            logic inc;
            logic dec;
            inc = upd.valid && (upd.zone == ZW'(i));
            dec = upd.valid && upd.evict && (upd.old_zone == ZW'(i)) &&
                  (tally_reg[i] != '0);
            tally_next[i] = tally_reg[i] + {{(TW-1){1'b0}}, inc}
                                         - {{(TW-1){1'b0}}, dec};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ZN; i++) begin
                tally_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < ZN; i++) begin
                tally_reg[i] <= tally_next[i];
            end
        end
    end

    // Argmax over the updated counts; the lower id keeps ties
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (tally_next[2*i+1] > tally_next[2*i]) begin
                v1[i] = tally_next[2*i+1];
                z1[i] = ZW'(2*i+1);
            end else begin
                v1[i] = tally_next[2*i];
                z1[i] = ZW'(2*i);
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (v1[2*i+1] > v1[2*i]) begin
                v2[i] = v1[2*i+1];
                z2[i] = z1[2*i+1];
            end else begin
                v2[i] = v1[2*i];
                z2[i] = z1[2*i];
            end
        end
        for (int i = 0; i < 2; i++) begin
            if (v2[2*i+1] > v2[2*i]) begin
                v3[i] = v2[2*i+1];
                z3[i] = z2[2*i+1];
            end else begin
                v3[i] = v2[2*i];
                z3[i] = z2[2*i];
            end
        end
        if (v3[1] > v3[0]) begin
            best_votes = v3[1];
            best_zone  = z3[1];
        end else begin
            best_votes = v3[0];
            best_zone  = z3[0];
        end
    end

endmodule

`default_nettype wire

FILE: design/seat_zone_classifier_vote_filter.sv
// ----------------------------------------------------------------------------
// seat_zone_classifier_vote_filter
// Classifies position estimates into seat zones and filters the zone over a
// window of recent requests by majority vote.
//
//   channel | dir | tdata (low bit up)                    | tuser
//   s_      | in  | x_pos[15:0] y_pos[15:0] strongest_node | user_mode
//   m_      | out | position_id zone_now winner_votes      | -
//
// One request per cycle while m_ is not stalled; an accepted request is held in
// the a stage (window memory read at accept), then the tally update and argmax
// load the output register as it advances. The window memory has a registered
// read; a request reads its slot at accept and writes its zone there one stage
// later, so a read and a write in the same cycle hit different slots when WINDOW_DEPTH > 1.
// Reset clears counters and pointers; no clearing pass.
// A stalled m_ side holds the output register and backs up one request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seat_zone_classifier_vote_filter_defines.svh"

module seat_zone_classifier_vote_filter #(
    parameter int WINDOW_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // x_pos[15:0], y_pos[31:16], strongest_node[34:32]
    input  wire logic [1:0]  s_tuser,   // user_mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // position_id[3:0], zone_now[7:4], winner_votes[14:8]
);

    localparam int ZW    = szcvf_pkg::ZONE_W;
    localparam int TW    = szcvf_pkg::TALLY_W;
    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

    logic [ZW-1:0] win_mem [WINDOW_DEPTH];
    logic [ZW-1:0] rd_data_reg;

    logic              accept_s;
    logic              advance_b;
    logic              full;
    logic [ZW-1:0]     zone_s;

    logic [IDX_W-1:0]  head_reg,    head_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              a_valid_reg, a_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic [ZW-1:0]     a_zone_reg;
    logic [IDX_W-1:0]  a_idx_reg;
    logic              a_evict_reg;

    logic [ZW-1:0]     pos_reg;
    logic [ZW-1:0]     zone_now_reg;
    logic [TW-1:0]     votes_reg;

    szcvf_pkg::tally_upd_t upd;
    logic [ZW-1:0]     best_zone;
    logic [TW-1:0]     best_votes;

    szcvf_classify u_classify (
        .x_pos          ($signed(s_tdata[15:0])),
        .y_pos          ($signed(s_tdata[31:16])),
        .user_mode      (s_tuser),
        .strongest_node (s_tdata[34:32]),
        .zone           (zone_s)
    );

    assign advance_b = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || advance_b;
    assign accept_s  = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_FULL);

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        a_valid_next = a_valid_reg;
        m_valid_next = m_valid_reg;
        if (accept_s) begin
            head_next = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
            if (!full) begin
                count_next = count_reg + 1'b1;
            end
        end
        if (accept_s) begin
            a_valid_next = 1'b1;
        end else if (advance_b) begin
            a_valid_next = 1'b0;
        end
        if (advance_b) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Read the entry to evict at accept; write the new zone one stage later.
    // The write address trails the read address by one slot, so with WINDOW_DEPTH > 1 they never collide.
    always_ff @(posedge aclk) begin
        if (accept_s) begin
            rd_data_reg <= win_mem[head_reg];
        end
        if (advance_b) begin
            win_mem[a_idx_reg] <= a_zone_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_s) begin
            a_zone_reg  <= zone_s;
            a_idx_reg   <= head_reg;
            a_evict_reg <= full;
        end
    end

    always_comb begin
        upd.valid    = advance_b;
        upd.zone     = a_zone_reg;
        upd.evict    = a_evict_reg;
        upd.old_zone = rd_data_reg;
    end

    szcvf_tally u_tally (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd        (upd),
        .best_zone  (best_zone),
        .best_votes (best_votes)
    );

    always_ff @(posedge aclk) begin
        if (advance_b) begin
            pos_reg      <= (best_votes < szcvf_pkg::VOTE_MIN) ? szcvf_pkg::ZONE_FINDING
                                                               : best_zone;
            zone_now_reg <= a_zone_reg;
            votes_reg    <= best_votes;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, votes_reg, zone_now_reg, pos_reg};

    `SZCVF_CHECK(fill_in_range, count_reg <= CNT_FULL)
    `SZCVF_CHECK(head_in_range, head_reg <= IDX_LAST)
    `SZCVF_CHECK(stall_blocks_input, (a_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
    `SZCVF_CHECK_RST(reset_empties_pipe, !aresetn |=> (!a_valid_reg && !m_valid_reg))

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Seat zone classifier vote filter testbench
// Sends position fixes over the s_ stream and checks every m_ result against
// a cycle-free predictor of the rectangle classifier and the majority vote
// over the recent-zone window. Both sides idle at random; a drain pause and a
// stretch of back-to-back traffic are included.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILTER_DEPTH = 8;
    localparam int RANDOM_FIXES = 1250;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [1:0] MODE_OTHER = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] NODE_NONE  = 3'd0;
    localparam logic [2:0] NODE_HIGH  = 3'd7;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [1:0]         mode;
        logic [2:0]         node;
        bit                 hold;   // wait for all results before sending
    } pos_fix_t;

    typedef struct packed {
        logic [3:0] position_id;
        logic [3:0] zone_now;
        logic [6:0] votes;
    } zone_report_t;

    typedef struct packed {
        int xlo;
        int xhi;
        int ylo;
        int yhi;
    } seat_box_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // x_pos[15:0], y_pos[31:16], strongest_node[34:32]
    logic [1:0]  s_tuser = '0;   // user_mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // position_id[3:0], zone_now[7:4], winner_votes[14:8]

    pos_fix_t     fix_queue [$];
    zone_report_t report_queue [$];

    logic [3:0] vote_window [FILTER_DEPTH];
    int         vote_tally [16];
    int         win_ptr = 0;
    int         win_fill = 0;

    int n_sent = 0;
    int n_recv = 0;
    int n_errors = 0;
    int n_confirmed = 0;
    int idle_cycles = 0;
    logic [15:0] zones_seen = '0;

    seat_zone_classifier_vote_filter #(.WINDOW_DEPTH(FILTER_DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Half-open bounds of each zone, in Q8.8
    function automatic seat_box_t seat_box(int zone);
        case (zone)
            3:       return '{-5120,   102, -5120,   179};
            4:       return '{-5120,   102,   179,  5120};
            5:       return '{  102,  5120, -5120,   102};
            6:       return '{  102,  5120,   102,   179};
            7:       return '{  102,  5120,   179,  5120};
            8:       return '{ -256,   768, -5120,   179};
            9:       return '{ -256,   768,   179,  5120};
            10:      return '{-5120,   179,  -128,   512};
            11:      return '{  179,  5120,  -128,   512};
            12:      return '{-5120,  -256, -5120,  -128};
            13:      return '{  768,  5120, -5120,  -128};
            14:      return '{-5120,  -256,   512,  5120};
            default: return '{  768,  5120,   512,  5120};
        endcase
    endfunction

    function automatic logic [3:0] seat_zone_of(logic signed [15:0] x, logic signed [15:0] y,
                                                 logic [1:0] mode, logic [2:0] node);
        int        xi;
        int        yi;
        int        first;
        int        last;
        logic [3:0] zone;
        seat_box_t b;
        xi = x;
        yi = y;
        zone = szcvf_pkg::ZONE_FINDING;
        if (xi == 0 && yi == 0) return szcvf_pkg::ZONE_FINDING;
        if (mode == szcvf_pkg::MODE_IN_CAR) begin
            first = 3;
            last = 7;
        end else if (mode == szcvf_pkg::MODE_OUT_CAR) begin
            first = 8;
            last = 15;
        end else begin
            return szcvf_pkg::ZONE_FINDING;
        end
        // scan from the top so the lowest matching zone is kept
        for (int z = last; z >= first; z--) begin
            b = seat_box(z);
            if (xi >= b.xlo && xi < b.xhi && yi >= b.ylo && yi < b.yhi) zone = 4'(z);
        end
        if (mode == szcvf_pkg::MODE_IN_CAR) begin
            case (node)
                szcvf_pkg::NODE_DRIVER:    zone = szcvf_pkg::ZONE_DRIVER;
                szcvf_pkg::NODE_PASSENGER: zone = szcvf_pkg::ZONE_PASSENGER;
                szcvf_pkg::NODE_BACK_L:    zone = szcvf_pkg::ZONE_BACK_L;
                szcvf_pkg::NODE_BACK_R:    zone = szcvf_pkg::ZONE_BACK_R;
                default: ;
            endcase
        end
        return zone;
    endfunction

    // Push the zone into the window and return the majority vote
    function automatic zone_report_t cast_vote(logic [3:0] zone);
        zone_report_t r;
        int           best;
        int           votes;
        if (win_fill == FILTER_DEPTH) vote_tally[vote_window[win_ptr]]--;
        else win_fill++;
        vote_window[win_ptr] = zone;
        vote_tally[zone]++;
        win_ptr = (win_ptr + 1) % FILTER_DEPTH;
        best = 0;
        votes = 0;
        for (int i = 0; i < 16; i++) begin
            if (vote_tally[i] > votes) begin
                votes = vote_tally[i];
                best = i;
            end
        end
        r.position_id = (votes < 2) ? szcvf_pkg::ZONE_FINDING : 4'(best);
        r.zone_now = zone;
        r.votes = 7'(votes);
        return r;
    endfunction

    // Driver
    always @(posedge aclk) begin
        bit       s_acc;
        bit       m_acc;
        bit       calm;
        int       pending;
        pos_fix_t f;
        if (aresetn) begin
            s_acc = s_tvalid && s_tready;
            m_acc = m_tvalid && m_tready;
            calm = n_sent >= 400 && n_sent < 650;
            if (s_acc) begin
                report_queue.push_back(cast_vote(seat_zone_of(s_tdata[15:0], s_tdata[31:16],
                                                              s_tuser, s_tdata[34:32])));
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_acc) begin
                pending = n_sent + int'(s_acc) - n_recv - int'(m_acc);
                if (fix_queue.size() == 0 || (fix_queue[0].hold && pending != 0) ||
                    (!calm && $urandom_range(99) < 31)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    f = fix_queue.pop_front();
                    s_tdata <= {5'b0, f.node, f.y, f.x};
                    s_tuser <= f.mode;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        zone_report_t want;
        zone_report_t got;
        if (aresetn) begin
            m_tready <= (n_recv >= 400 && n_recv < 650) || $urandom_range(99) >= 31;
            if (m_tvalid && m_tready) begin
                got = {m_tdata[3:0], m_tdata[7:4], m_tdata[14:8]};
                if (n_sent == n_recv) begin
                    $display("%0t: unexpected result pos %0d zone %0d votes %0d", $time,
                             got.position_id, got.zone_now, got.votes);
                    n_errors <= n_errors + 1;
                end else begin
                    want = report_queue.pop_front();
                    n_recv <= n_recv + 1;
                    zones_seen[got.zone_now] <= 1'b1;
                    if (got.position_id != szcvf_pkg::ZONE_FINDING) begin
                        n_confirmed <= n_confirmed + 1;
                    end
                    if (got !== want) begin
                        $display({"%0t: result %0d expected pos %0d zone %0d votes %0d,",
                                  " got pos %0d zone %0d votes %0d"},
                                 $time, n_recv, want.position_id, want.zone_now, want.votes,
                                 got.position_id, got.zone_now, got.votes);
                        n_errors <= n_errors + 1;
                    end
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_fix(int x, int y, logic [1:0] mode, logic [2:0] node, bit hold = 1'b0);
        pos_fix_t f;
        f.x = 16'(x);
        f.y = 16'(y);
        f.mode = mode;
        f.node = node;
        f.hold = hold;
        fix_queue.push_back(f);
    endtask

    initial begin
        int cut_lines [8];
        int cx;
        int cy;
        int run_len;
        int pick;
        logic [1:0] mode;
        logic [2:0] node;

        cut_lines = '{-5120, -256, -128, 102, 179, 512, 768, 5120};
        for (int i = 0; i < 16; i++) vote_tally[i] = 0;

        // origin wins over any mode and node
        add_fix(0, 0, szcvf_pkg::MODE_IN_CAR, szcvf_pkg::NODE_DRIVER);
        add_fix(0, 0, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);
        // unknown modes
        add_fix(500, 500, MODE_OTHER, szcvf_pkg::NODE_PASSENGER);
        add_fix(-32768, 32767, MODE_SPARE, NODE_HIGH);
        // no match, in car and out of car, and override of a no-match point
        add_fix(-32768, -32768, szcvf_pkg::MODE_IN_CAR, NODE_NONE);
        add_fix(32767, 32767, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);
        add_fix(32767, -32768, szcvf_pkg::MODE_IN_CAR, szcvf_pkg::NODE_BACK_R);
        // in-car zones, then the edges between them
        add_fix(-100, 0, szcvf_pkg::MODE_IN_CAR, NODE_NONE);
        add_fix(0, 500, szcvf_pkg::MODE_IN_CAR, NODE_NONE);
        add_fix(500, 0, szcvf_pkg::MODE_IN_CAR, NODE_NONE);
        add_fix(500, 150, szcvf_pkg::MODE_IN_CAR, NODE_NONE);
        add_fix(500, 500, szcvf_pkg::MODE_IN_CAR, NODE_NONE);
        add_fix(102, 179, szcvf_pkg::MODE_IN_CAR, 3'd5);
        add_fix(5119, 102, szcvf_pkg::MODE_IN_CAR, 3'd6);
        add_fix(5120, 0, szcvf_pkg::MODE_IN_CAR, NODE_NONE);
        // node overrides on a driver-seat point
        add_fix(-100, 0, szcvf_pkg::MODE_IN_CAR, szcvf_pkg::NODE_PASSENGER);
        add_fix(-100, 0, szcvf_pkg::MODE_IN_CAR, szcvf_pkg::NODE_BACK_L);
        // out-of-car zones
        add_fix(100, -1000, szcvf_pkg::MODE_OUT_CAR, szcvf_pkg::NODE_DRIVER);
        add_fix(100, 1000, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);
        add_fix(-1000, 0, szcvf_pkg::MODE_OUT_CAR, NODE_NONE, 1'b1);
        add_fix(1000, 0, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);
        add_fix(-1000, -1000, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);
        add_fix(1000, -1000, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);
        add_fix(-1000, 1000, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);
        add_fix(1000, 1000, szcvf_pkg::MODE_OUT_CAR, NODE_NONE);

        // Random part: mostly runs of nearby fixes so the vote settles
        while (fix_queue.size() < 25 + RANDOM_FIXES) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(99) < 30) begin
                    cx = cut_lines[$urandom_range(7)];
                    cy = cut_lines[$urandom_range(7)];
                end else begin
                    cx = $urandom_range(12000) - 6000;
                    cy = $urandom_range(12000) - 6000;
                end
                pick = $urandom_range(99);
                mode = (pick < 45) ? szcvf_pkg::MODE_IN_CAR :
                       (pick < 90) ? szcvf_pkg::MODE_OUT_CAR : 2'($urandom_range(3));
                node = ($urandom_range(99) < 70) ? NODE_NONE : 3'($urandom_range(7));
                run_len = $urandom_range(12, 1);
                for (int k = 0; k < run_len; k++) begin
                    if ($urandom_range(99) < 10) node = 3'($urandom_range(7));
                    add_fix(cx + $urandom_range(80) - 40, cy + $urandom_range(80) - 40, mode,
                            node, (fix_queue.size() % 250) == 100);
                end
            end else if (pick < 90) begin
                add_fix($urandom_range(11000) - 5500, $urandom_range(11000) - 5500,
                        2'($urandom_range(1)), 3'($urandom_range(7)));
            end else if (pick < 93) begin
                add_fix(0, 0, 2'($urandom_range(3)), 3'($urandom_range(7)));
            end else begin
                add_fix($urandom_range(65535), $urandom_range(65535), 2'($urandom_range(3)),
                        3'($urandom_range(7)));
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait (fix_queue.size() == 0 && !s_tvalid);
        wait (n_recv == n_sent);
        repeat (10) @(posedge aclk);

        $display("%0d position fixes checked over all modes, nodes and window fill levels",
                 n_recv);
        $display("%0d results held a confirmed seat zone; zone mask seen 0x%04h",
                 n_confirmed, zones_seen);
        if (n_errors == 0 && report_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
